// ===== rtl/lkvc_pkg.sv =====
// Package: shared constants, codes and control types for the LRU key/value cache.
`timescale 1ns / 1ps
`default_nettype none
package lkvc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] STATUS_HIT    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EVICT  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd3;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [DATA_W-1:0] NO_VALUE = {DATA_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_EMIT
    } lkvc_state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
        logic emit;
    } lkvc_cmd_t;

    typedef struct packed {
        logic out_stall;
    } lkvc_stat_t;

endpackage
`default_nettype wire

// ===== rtl/lkvc_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/lkvc_ctrl.sv =====
// Controller: sequences capture, lookup, update and result load for one word.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire lkvc_pkg::lkvc_stat_t  stat,
    output lkvc_pkg::lkvc_cmd_t        cmd
);

    lkvc_pkg::lkvc_state_t state_reg;
    lkvc_pkg::lkvc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lkvc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = lkvc_pkg::ST_LOOKUP;
                end
            end
            lkvc_pkg::ST_LOOKUP: begin
                state_next = lkvc_pkg::ST_UPDATE;
            end
            lkvc_pkg::ST_UPDATE: begin
                state_next = lkvc_pkg::ST_EMIT;
            end
            lkvc_pkg::ST_EMIT: begin
                if (!stat.out_stall) begin
                    state_next = lkvc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = (state_reg == lkvc_pkg::ST_IDLE);
        cmd.capture = (state_reg == lkvc_pkg::ST_IDLE) && s_valid;
        cmd.lookup  = (state_reg == lkvc_pkg::ST_LOOKUP);
        cmd.update  = (state_reg == lkvc_pkg::ST_UPDATE);
        cmd.emit    = (state_reg == lkvc_pkg::ST_EMIT) && !stat.out_stall;
    end

endmodule
`default_nettype wire

// ===== rtl/lkvc_datapath.sv =====
// Datapath: key match array, recency ranks, value RAM and output register.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_datapath #(
    parameter int  ENTRIES = lkvc_pkg::ENTRIES_DEF,
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lkvc_pkg::lkvc_cmd_t           cmd,
    output lkvc_pkg::lkvc_stat_t               stat,
    input  wire logic                          s_cmd,
    input  wire logic signed [31:0]            s_key,
    input  wire logic signed [31:0]            s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lkvc_pkg::STATUS_W-1:0]      m_status,
    output logic signed [31:0]                 m_read_value
);

    localparam int DW = lkvc_pkg::DATA_W;
    localparam logic [IDX_W-1:0] OLDEST = IDX_W'(ENTRIES - 1);

    logic                cmd_reg;
    logic [DW-1:0]       key_reg;
    logic [DW-1:0]       value_reg;

    logic [DW-1:0]       keys_reg  [ENTRIES];
    logic [IDX_W-1:0]    age_reg   [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg;

    logic [IDX_W-1:0]    slot_reg;
    logic [IDX_W-1:0]    hit_age_reg;
    logic                promote_all_reg;
    logic                write_reg;
    logic                read_reg;
    logic [lkvc_pkg::STATUS_W-1:0] status_reg;

    logic                m_valid_reg;
    logic [lkvc_pkg::STATUS_W-1:0] m_status_reg;
    logic [DW-1:0]       m_read_value_reg;

    logic [ENTRIES-1:0]  hit_vec;
    logic [IDX_W-1:0]    hit_idx;
    logic [IDX_W-1:0]    hit_age;
    logic [IDX_W-1:0]    victim_idx;
    logic [IDX_W-1:0]    free_idx;
    logic                any_hit;
    logic                full;
    logic                reject;
    logic                promote;
    logic [DW-1:0]       ram_rdata;

    // capture input word
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg   <= s_cmd;
            key_reg   <= s_key;
            value_reg <= s_value;
        end
    end

    // parallel match, rank lookup, victim and free slot search
    always_comb begin
        hit_idx    = '0;
        hit_age    = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = valid_reg[i] && (keys_reg[i] == key_reg);
            if (hit_vec[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
                hit_age = hit_age | age_reg[i];
            end
            if (valid_reg[i] && (age_reg[i] == OLDEST)) begin
                victim_idx = victim_idx | IDX_W'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
        any_hit = |hit_vec;
        full    = &valid_reg;
        reject  = key_reg[DW-1] || (key_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            hit_age_reg     <= hit_age;
            promote_all_reg <= !any_hit;
            if (any_hit) begin
                slot_reg <= hit_idx;
            end else if (full) begin
                slot_reg <= victim_idx;
            end else begin
                slot_reg <= free_idx;
            end
            if (cmd_reg == lkvc_pkg::CMD_GET) begin
                write_reg  <= 1'b0;
                read_reg   <= any_hit;
                status_reg <= any_hit ? lkvc_pkg::STATUS_HIT : lkvc_pkg::STATUS_MISS;
            end else begin
                read_reg  <= 1'b0;
                write_reg <= !reject;
                priority if (reject) begin
                    status_reg <= lkvc_pkg::STATUS_REJECT;
                end else if (any_hit) begin
                    status_reg <= lkvc_pkg::STATUS_HIT;
                end else if (full) begin
                    status_reg <= lkvc_pkg::STATUS_EVICT;
                end else begin
                    status_reg <= lkvc_pkg::STATUS_MISS;
                end
            end
        end
    end

    assign promote = cmd.update && (write_reg || read_reg);

    // age entries more recent than the promoted one (every valid entry on a miss), make it newest
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                age_reg[i] <= '0;
            end
        end else if (promote) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IDX_W'(i) == slot_reg) begin
                    age_reg[i] <= '0;
                end else if (valid_reg[i] && (promote_all_reg || age_reg[i] < hit_age_reg)) begin
                    age_reg[i] <= age_reg[i] + IDX_W'(1);
                end
            end
            if (write_reg) begin
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update && write_reg) begin
            keys_reg[slot_reg] <= key_reg;
        end
    end

    lkvc_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (cmd.update && write_reg),
        .addr  (slot_reg),
        .wdata (value_reg),
        .rdata (ram_rdata)
    );

    // hold result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status_reg     <= status_reg;
            m_read_value_reg <= read_reg ? ram_rdata : lkvc_pkg::NO_VALUE;
        end
    end

    assign stat.out_stall = m_valid_reg && !m_ready;
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_read_value   = m_read_value_reg;

endmodule
`default_nettype wire

// ===== rtl/lru_key_value_cache.sv =====
// Top level: fully associative LRU key/value cache, controller plus datapath.
//
//  channel | ports                                | role
//  --------+--------------------------------------+---------------------------
//  s_      | s_valid s_ready s_cmd s_key s_value  | get/put request word in
//  m_      | m_valid m_ready m_status m_read_value| one result word per request
//
// A request steps through capture at acceptance, then parallel key match, rank and
// value RAM update, and result load (after the registered RAM read); a new request
// is taken only once the controller is back in idle, after the result is loaded.
// Input ready returns with the loaded result.
// Reset clears the valid bits and ranks at once; no clearing pass is needed.
// A stalled result only holds the controller in its load step.
`timescale 1ns / 1ps
`default_nettype none
module lru_key_value_cache #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic signed [31:0]            s_key,
    input  wire logic signed [31:0]            s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lkvc_pkg::STATUS_W-1:0]      m_status,
    output logic signed [31:0]                 m_read_value
);

    lkvc_pkg::lkvc_cmd_t  cmd;
    lkvc_pkg::lkvc_stat_t stat;

    lkvc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lkvc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_cmd        (s_cmd),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_read_value (m_read_value)
    );

endmodule
`default_nettype wire

// ===== rtl/lkvc_checker.sv =====
// Checker: port-level properties of the cache, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [lkvc_pkg::STATUS_W-1:0] m_status,
    input wire logic [31:0]                   m_read_value
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_status) && $stable(m_read_value)))
        else $error("result word changed while stalled");

    a_no_value_off_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != lkvc_pkg::STATUS_HIT)) |-> (m_read_value == lkvc_pkg::NO_VALUE))
        else $error("read value other than -1 without a hit");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while one is in progress");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared the cycle after request acceptance");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_read_value (m_read_value)
);
`default_nettype wire
